>>> sv/priority_sound_request_queue_core_assert.svh
// Assertion macros for the priority sound request queue core.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef PRIORITY_SOUND_REQUEST_QUEUE_CORE_ASSERT_SVH
`define PRIORITY_SOUND_REQUEST_QUEUE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSRQ_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("psrq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PSRQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("psrq assertion failed");

`endif

>>> sv/psrq_pkg.sv
// Shared types, constants and the control store of the sound request queue.
// No dependencies.
package psrq_pkg;

  localparam int CH_W   = 2;
  localparam int NOTE_W = 16;
  localparam int PRIO_W = 16;
  localparam int MASK_W = 3;

  localparam logic FUNC_REQ  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE    = 4'd0;
  localparam step_t ST_RQ_PTR  = 4'd1;
  localparam step_t ST_RQ_RD   = 4'd2;
  localparam step_t ST_RQ_CHK  = 4'd3;
  localparam step_t ST_TK_PTR  = 4'd4;
  localparam step_t ST_TK_SCAN = 4'd5;
  localparam step_t ST_TK_RD   = 4'd6;
  localparam step_t ST_TK_LOAD = 4'd7;
  localparam step_t ST_TK_EMIT = 4'd8;
  localparam step_t ST_TK_CLR  = 4'd9;

  typedef enum logic [2:0] {
    BR_SEQ,
    BR_JMP,
    BR_DISP,
    BR_HIT,
    BR_SCAN,
    BR_EMIT
  } br_t;

  typedef struct packed {
    br_t   br;
    step_t tgt_a;
    step_t tgt_b;
    logic  accept;
    logic  ld_ptr;
    logic  adv;
    logic  ram_rd;
    logic  ram_wr;
    logic  set_ri;
    logic  ld_note;
    logic  clr_note;
    logic  emit;
    logic  clr_valid;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic ld_ptr;
    logic adv;
    logic ram_rd;
    logic ram_wr;
    logic set_ri;
    logic ld_note;
    logic clr_note;
    logic emit;
    logic clr_valid;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_tick;
    logic ch_ok;
    logic hit;
    logic found;
    logic free;
    logic scan_end;
    logic out_free;
    logic ch_last;
  } status_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    unique case (s)
      ST_IDLE:    w = '{br: BR_DISP, tgt_a: ST_TK_PTR, tgt_b: ST_RQ_PTR, accept: 1'b1,
                        default: '0};
      ST_RQ_PTR:  w = '{br: BR_SEQ, ld_ptr: 1'b1, default: '0};
      ST_RQ_RD:   w = '{br: BR_SEQ, ram_rd: 1'b1, default: '0};
      ST_RQ_CHK:  w = '{br: BR_HIT, tgt_a: ST_IDLE, tgt_b: ST_RQ_RD, ram_wr: 1'b1,
                        adv: 1'b1, default: '0};
      ST_TK_PTR:  w = '{br: BR_SEQ, ld_ptr: 1'b1, clr_note: 1'b1, default: '0};
      ST_TK_SCAN: w = '{br: BR_SCAN, tgt_a: ST_TK_RD, tgt_b: ST_TK_EMIT, adv: 1'b1,
                        default: '0};
      ST_TK_RD:   w = '{br: BR_SEQ, ram_rd: 1'b1, set_ri: 1'b1, default: '0};
      ST_TK_LOAD: w = '{br: BR_SEQ, ld_note: 1'b1, default: '0};
      ST_TK_EMIT: w = '{br: BR_EMIT, tgt_a: ST_TK_CLR, tgt_b: ST_TK_PTR, emit: 1'b1,
                        default: '0};
      ST_TK_CLR:  w = '{br: BR_JMP, tgt_a: ST_IDLE, clr_valid: 1'b1, default: '0};
      default:    w = '{br: BR_JMP, tgt_a: ST_IDLE, default: '0};
    endcase
    return w;
  endfunction

endpackage

>>> sv/psrq_if.sv
// Valid/ready channel interfaces for request/tick words and result words.
// Depends on psrq_pkg.
interface psrq_in_if import psrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [CH_W-1:0]   channel;
  logic [NOTE_W-1:0] note_handle;
  logic [PRIO_W-1:0] priority_req;
  logic [MASK_W-1:0] channel_busy_mask;
  logic [MASK_W-1:0] channel_looping_mask;

  modport source (output valid, func, channel, note_handle, priority_req,
                  channel_busy_mask, channel_looping_mask, input ready);
  modport sink (input valid, func, channel, note_handle, priority_req,
                channel_busy_mask, channel_looping_mask, output ready);
endinterface

interface psrq_out_if import psrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   out_channel;
  logic              start_res;
  logic [NOTE_W-1:0] start_note;
  logic              last;

  modport source (output valid, out_channel, start_res, start_note, last, input ready);
  modport sink (input valid, out_channel, start_res, start_note, last, output ready);
endinterface

>>> sv/psrq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module psrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/psrq_seq.sv
// Microcode sequencer: step counter, control store lookup and branch decode.
// Depends on psrq_pkg.
module psrq_seq import psrq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;

  assign uw = ucode(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    ctrl.accept    = uw.accept;
    ctrl.ld_ptr    = uw.ld_ptr;
    ctrl.adv       = uw.adv;
    ctrl.ram_rd    = uw.ram_rd;
    ctrl.ram_wr    = uw.ram_wr && status.hit;
    ctrl.set_ri    = uw.set_ri;
    ctrl.ld_note   = uw.ld_note;
    ctrl.clr_note  = uw.clr_note;
    ctrl.emit      = uw.emit && status.out_free;
    ctrl.clr_valid = uw.clr_valid;
    step_nxt       = step_r;
    unique case (uw.br)
      BR_SEQ: step_nxt = step_r + 4'd1;
      BR_JMP: step_nxt = uw.tgt_a;
      BR_DISP: begin
        if (status.in_valid) begin
          if (status.is_tick) begin
            step_nxt = uw.tgt_a;
          end else if (status.ch_ok) begin
            step_nxt = uw.tgt_b;
          end
        end
      end
      BR_HIT: begin
        ctrl.adv = uw.adv && !status.hit;
        step_nxt = (status.hit || status.scan_end) ? uw.tgt_a : uw.tgt_b;
      end
      BR_SCAN: begin
        ctrl.adv = uw.adv && !status.found;
        if (status.found && status.free) begin
          step_nxt = uw.tgt_a;
        end else if (status.found || status.scan_end) begin
          step_nxt = uw.tgt_b;
        end
      end
      BR_EMIT: begin
        if (status.out_free) begin
          step_nxt = status.ch_last ? uw.tgt_a : uw.tgt_b;
        end
      end
      default: step_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> sv/psrq_dp.sv
// Datapath: slot valid bits, read indexes, slot RAM, scan pointer, result register.
// Depends on psrq_pkg, psrq_if and psrq_ram.
module psrq_dp import psrq_pkg::*; #(
  parameter int CHANNELS = 3,
  parameter int SLOTS    = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ctrl_t           ctrl,
  output status_t         status,
  psrq_in_if.sink         in_if,
  psrq_out_if.source      out_if
);

  localparam int DEPTH = CHANNELS * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RW    = NOTE_W + PRIO_W;

  logic [DEPTH-1:0]  valid_r;
  logic [SW-1:0]     read_index_r [CHANNELS];
  logic [CW-1:0]     ch_r;
  logic [SW-1:0]     s_r;
  logic [SW-1:0]     cnt_r;
  logic [NOTE_W-1:0] note_r;
  logic [PRIO_W-1:0] prio_r;
  logic [MASK_W-1:0] busy_r;
  logic [MASK_W-1:0] loop_r;
  logic              start_r;
  logic              out_valid_r;
  logic [CH_W-1:0]   out_channel_r;
  logic              out_start_r;
  logic [NOTE_W-1:0] out_note_r;
  logic              out_last_r;

  logic [AW-1:0]     addr;
  logic [SW-1:0]     s_next;
  logic [RW-1:0]     rdata;
  logic [7:0]        busy_ext;
  logic [7:0]        loop_ext;
  logic              vbit;
  logic              in_acc;

  assign addr     = AW'(32'(ch_r) * SLOTS + 32'(s_r));
  assign s_next   = (32'(s_r) == SLOTS - 1) ? '0 : SW'(s_r + 1'b1);
  assign vbit     = valid_r[addr];
  assign busy_ext = {{(8 - MASK_W){1'b0}}, busy_r};
  assign loop_ext = {{(8 - MASK_W){1'b0}}, loop_r};
  assign in_acc   = in_if.valid && ctrl.accept;

  psrq_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ctrl.ram_wr),
    .waddr (addr),
    .wdata ({note_r, prio_r}),
    .re    (ctrl.ram_rd),
    .raddr (addr),
    .rdata (rdata)
  );

  always_comb begin
    status.in_valid = in_if.valid;
    status.is_tick  = (in_if.func == FUNC_TICK);
    status.ch_ok    = (32'(in_if.channel) < CHANNELS);
    status.hit      = !vbit || (prio_r > rdata[PRIO_W-1:0]);
    status.found    = vbit;
    status.free     = !busy_ext[3'(ch_r)] || loop_ext[3'(ch_r)];
    status.scan_end = (32'(cnt_r) == SLOTS - 1);
    status.out_free = !out_valid_r || out_if.ready;
    status.ch_last  = (32'(ch_r) == CHANNELS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        read_index_r[c] <= '0;
      end
    end else begin
      if (ctrl.clr_valid) begin
        valid_r <= '0;
      end else if (ctrl.ram_wr) begin
        valid_r[addr] <= 1'b1;
      end
      if (ctrl.set_ri) begin
        read_index_r[ch_r] <= s_next;
      end
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r   <= (in_if.func == FUNC_TICK) ? '0 : CW'(in_if.channel);
      note_r <= in_if.note_handle;
      prio_r <= in_if.priority_req;
      busy_r <= in_if.channel_busy_mask;
      loop_r <= in_if.channel_looping_mask;
    end else if (ctrl.emit) begin
      ch_r <= CW'(ch_r + 1'b1);
    end
    if (ctrl.ld_ptr) begin
      s_r   <= read_index_r[ch_r];
      cnt_r <= '0;
    end else if (ctrl.adv) begin
      s_r   <= s_next;
      cnt_r <= SW'(cnt_r + 1'b1);
    end
    if (ctrl.clr_note) begin
      note_r  <= '0;
      start_r <= 1'b0;
    end else if (ctrl.ld_note) begin
      note_r  <= rdata[RW-1:PRIO_W];
      start_r <= 1'b1;
    end
    if (ctrl.emit) begin
      out_channel_r <= CH_W'(ch_r);
      out_start_r   <= start_r;
      out_note_r    <= note_r;
      out_last_r    <= status.ch_last;
    end
  end

  assign in_if.ready        = ctrl.accept;
  assign out_if.valid       = out_valid_r;
  assign out_if.out_channel = out_channel_r;
  assign out_if.start_res   = out_start_r;
  assign out_if.start_note  = out_note_r;
  assign out_if.last        = out_last_r;

endmodule

>>> sv/priority_sound_request_queue_core.sv
// Request word: the scan pointer is loaded, then k slots (1..SLOTS) are examined, each by a
// read of the one slot RAM port and a compare, until a slot is written or all are seen.
// Tick word: per channel the pointer is loaded and j slots (1..SLOTS) scanned, one valid bit
// a cycle; a found note is fetched if the channel is free, then the result waits for a free
// output; finally all requests expire. Reset (rst_n low, synchronous) clears valid bits, read
// indexes, step counter and result valid bit; the slot RAM holds no reset, needs no clearing pass.
`include "priority_sound_request_queue_core_assert.svh"

module priority_sound_request_queue_core import psrq_pkg::*; #(
  parameter int CHANNELS = 3,
  parameter int SLOTS    = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  psrq_in_if.sink    in_if,
  psrq_out_if.source out_if
);

  ctrl_t   ctrl;
  status_t status;

  psrq_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  psrq_dp #(.CHANNELS(CHANNELS), .SLOTS(SLOTS)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .status (status),
    .in_if  (in_if),
    .out_if (out_if)
  );

  `PSRQ_ASSERT_SAME(a_emit_free, ctrl.emit, !out_if.valid || out_if.ready)
  `PSRQ_ASSERT_NEXT(a_wr_ends_req, ctrl.ram_wr, ctrl.accept)
  `PSRQ_ASSERT_NEXT(a_tick_busy, in_if.valid && in_if.ready && in_if.func == FUNC_TICK, !in_if.ready)
  `PSRQ_ASSERT_NEXT(a_clr_then_idle, ctrl.clr_valid, in_if.ready && !ctrl.emit)

endmodule

>>> sim/tb.sv
// Self-checking testbench for priority_sound_request_queue_core: a directed table of request
// and tick words, then random bursts, with results checked against an in-bench ring model.
// Depends on psrq_pkg, the interfaces in psrq_if.sv and the core itself.
module tb;
  import psrq_pkg::*;

  localparam int CHANNELS    = 3;
  localparam int SLOTS       = 16;
  localparam int WORDS       = 480;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic              start;
    logic [NOTE_W-1:0] note;
    logic              last;
  } chan_report_t;

  typedef struct packed {
    logic                             func;
    logic [CH_W-1:0]                  ch;
    logic [NOTE_W-1:0]                note;
    logic [PRIO_W-1:0]                prio;
    logic [MASK_W-1:0]                busy;
    logic [MASK_W-1:0]                loop_m;
    logic                             typed;
    logic [CHANNELS-1:0]              t_start;
    logic [CHANNELS-1:0][NOTE_W-1:0]  t_note;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  psrq_in_if  in_ch();
  psrq_out_if out_ch();

  priority_sound_request_queue_core #(.CHANNELS(CHANNELS), .SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch)
  );

  always #1 clk = ~clk;

  logic              slot_full   [CHANNELS][SLOTS];
  logic [NOTE_W-1:0] slot_note_m [CHANNELS][SLOTS];
  logic [PRIO_W-1:0] slot_prio_m [CHANNELS][SLOTS];
  int                head        [CHANNELS];
  chan_report_t      due_reports [$];
  int                mismatches   = 0;
  int                reports_seen = 0;
  int                words_sent   = 0;
  logic              no_idle      = 1'b0;

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void apply_request(logic [CH_W-1:0] ch, logic [NOTE_W-1:0] note,
                                        logic [PRIO_W-1:0] prio);
    int s;
    if (ch >= CHANNELS) return;
    s = head[ch];
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_full[ch][s] || prio > slot_prio_m[ch][s]) begin
        slot_full[ch][s]   = 1'b1;
        slot_note_m[ch][s] = note;
        slot_prio_m[ch][s] = prio;
        return;
      end
      s = (s + 1) % SLOTS;
    end
  endfunction

  function automatic void run_tick(logic [MASK_W-1:0] busy, logic [MASK_W-1:0] loop_m,
                                   output chan_report_t rep [CHANNELS]);
    int s;
    bit hit;
    for (int c = 0; c < CHANNELS; c++) begin
      s = head[c];
      hit = 1'b0;
      for (int i = 0; i < SLOTS && !hit; i++) begin
        if (slot_full[c][s]) hit = 1'b1;
        else s = (s + 1) % SLOTS;
      end
      rep[c] = '{ch: CH_W'(c), start: 1'b0, note: '0, last: (c == CHANNELS - 1)};
      if (hit && (!busy[c] || loop_m[c])) begin
        rep[c].start = 1'b1;
        rep[c].note  = slot_note_m[c][s];
        slot_full[c][s] = 1'b0;
        head[c] = (s + 1) % SLOTS;
      end
    end
    for (int c = 0; c < CHANNELS; c++)
      for (int i = 0; i < SLOTS; i++)
        slot_full[c][i] = 1'b0;
  endfunction

  function automatic stim_row_t req_row(int ch, int note, int prio);
    stim_row_t r;
    r = '0;
    r.func   = FUNC_REQ;
    r.ch     = CH_W'(ch);
    r.note   = NOTE_W'(note);
    r.prio   = PRIO_W'(prio);
    r.busy   = '1;
    r.loop_m = '1;
    return r;
  endfunction

  function automatic stim_row_t tick_row(int busy, int loop_m);
    stim_row_t r;
    r = '0;
    r.func   = FUNC_TICK;
    r.ch     = '1;
    r.note   = '1;
    r.prio   = '1;
    r.busy   = MASK_W'(busy);
    r.loop_m = MASK_W'(loop_m);
    return r;
  endfunction

  function automatic stim_row_t tick_row_exp(int busy, int loop_m, int starts,
                                             int n0, int n1, int n2);
    stim_row_t r;
    r = tick_row(busy, loop_m);
    r.typed     = 1'b1;
    r.t_start   = CHANNELS'(starts);
    r.t_note[0] = NOTE_W'(n0);
    r.t_note[1] = NOTE_W'(n1);
    r.t_note[2] = NOTE_W'(n2);
    return r;
  endfunction

  function automatic stim_row_t rand_req(int ch, bit narrow);
    stim_row_t r;
    r = req_row(ch, $urandom, narrow ? $urandom_range(0, 3) : $urandom);
    r.busy   = MASK_W'($urandom);
    r.loop_m = MASK_W'($urandom);
    return r;
  endfunction

  function automatic stim_row_t rand_tick();
    stim_row_t r;
    r = tick_row($urandom_range(0, 7), $urandom_range(0, 7));
    r.ch   = CH_W'($urandom);
    r.note = NOTE_W'($urandom);
    r.prio = PRIO_W'($urandom);
    return r;
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  task automatic put_word(stim_row_t r);
    chan_report_t rep [CHANNELS];
    int gap;
    in_ch.valid                <= 1'b1;
    in_ch.func                 <= r.func;
    in_ch.channel              <= r.ch;
    in_ch.note_handle          <= r.note;
    in_ch.priority_req         <= r.prio;
    in_ch.channel_busy_mask    <= r.busy;
    in_ch.channel_looping_mask <= r.loop_m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (r.func == FUNC_REQ) begin
      apply_request(r.ch, r.note, r.prio);
      if (r.ch < CHANNELS) words_sent++;
    end else begin
      run_tick(r.busy, r.loop_m, rep);
      for (int c = 0; c < CHANNELS; c++) begin
        if (r.typed) begin
          rep[c].start = r.t_start[c];
          rep[c].note  = r.t_note[c];
        end
        due_reports.push_back(rep[c]);
      end
      words_sent++;
    end
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    stim_row_t script [21];
    stim_row_t r;
    int kind;
    int n;
    int target;
    bit narrow;
    bit paused;
    for (int c = 0; c < CHANNELS; c++) begin
      head[c] = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_full[c][i]   = 1'b0;
        slot_note_m[c][i] = '0;
        slot_prio_m[c][i] = '0;
      end
    end
    rst_n                      <= 1'b0;
    in_ch.valid                <= 1'b0;
    in_ch.func                 <= FUNC_REQ;
    in_ch.channel              <= '0;
    in_ch.note_handle          <= '0;
    in_ch.priority_req         <= '0;
    in_ch.channel_busy_mask    <= '0;
    in_ch.channel_looping_mask <= '0;
    script = '{
      tick_row_exp(0, 0, 3'b000, 0, 0, 0),
      req_row(0, 'hFFFF, 'hFFFF),
      req_row(1, 0, 0),
      req_row(2, 'h1234, 1),
      req_row(3, 'hAAAA, 'hFFFF),
      tick_row_exp(7, 0, 3'b000, 0, 0, 0),
      req_row(0, 1, 5),
      req_row(0, 2, 5),
      req_row(0, 3, 6),
      req_row(1, 'hBEEF, 0),
      req_row(2, 'h5555, 'hFFFF),
      tick_row_exp(7, 5, 3'b101, 3, 0, 'h5555),
      tick_row_exp(0, 0, 3'b000, 0, 0, 0),
      req_row(2, 'hFFFF, 0),
      tick_row_exp(3, 0, 3'b100, 0, 0, 'hFFFF),
      req_row(0, 0, 0),
      req_row(0, 'hA5A5, 'hFFFF),
      tick_row(1, 0),
      req_row(1, 7, 0),
      tick_row(2, 2),
      tick_row(7, 7)
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (script[i]) put_word(script[i]);
    paused = 1'b0;
    while (words_sent < WORDS) begin
      no_idle = ($urandom_range(0, 9) < 2);
      if (!paused && words_sent >= WORDS / 2) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (due_reports.size() != 0);
      end
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        n = $urandom_range(1, 6);
        narrow = $urandom_range(0, 1);
        repeat (n)
          put_word(rand_req(($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, CHANNELS - 1),
                            narrow));
        put_word(rand_tick());
      end else if (kind < 85) begin
        target = $urandom_range(0, CHANNELS - 1);
        n = $urandom_range(SLOTS - 2, SLOTS + 4);
        repeat (n) put_word(rand_req(target, 1'b1));
        put_word(rand_tick());
      end else begin
        r = $urandom_range(0, 1) ? rand_tick()
                                 : rand_req($urandom_range(0, 3), $urandom_range(0, 1));
        put_word(r);
      end
    end
    in_ch.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    bit hold_done;
    chan_report_t want;
    stall_left = 0;
    hold_done  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        reports_seen++;
        if (due_reports.size() == 0) begin
          mismatches++;
          $display("%0t: expected no word, actual ch=%0d start=%0b note=%0h last=%0b", $time,
                   out_ch.out_channel, out_ch.start_res, out_ch.start_note, out_ch.last);
        end else begin
          want = due_reports.pop_front();
          check_field("out_channel", want.ch, out_ch.out_channel);
          check_field("start_res", want.start, out_ch.start_res);
          check_field("start_note", want.note, out_ch.start_note);
          check_field("last", want.last, out_ch.last);
        end
      end
      if (!hold_done && reports_seen >= 45) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_idle) stall_left = gap_len();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
